>>> hdl/kbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbc_pkg
// shared types, alphabet tables and helper functions for the keyed byte
// cipher nibble codec
// ----------------------------------------------------------------------------
package kbc_pkg;

  localparam int KEY_BYTES_MAX = 16;
  localparam int KEY_POS_W     = $clog2(KEY_BYTES_MAX);
  localparam int KEY_LEN_W     = KEY_POS_W + 1;
  localparam int ALPHA_COUNT   = 3;
  localparam int ALPHA_SIZE    = 16;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 5;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_DIRECTION  = 2'd0,
    REG_KEY_LENGTH = 2'd1,
    REG_KEY_LOW    = 2'd2,
    REG_KEY_HIGH   = 2'd3
  } reg_index_t;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef logic [7:0] byte_t;

  localparam byte_t ALPHA [ALPHA_COUNT][ALPHA_SIZE] = '{
    '{"a", "0", "s", "g", "A", "6", "u", "C", "d", "8", "w", "j", "5", "o", "G", "l"},
    '{"q", "I", "3", "b", "K", "F", "y", "x", "h", "t", "1", "e", "J", "L", "p", "m"},
    '{"D", "9", "k", "4", "z", "7", "f", "B", "r", "v", "i", "E", "c", "H", "2", "n"}
  };

  // nibble mod 3
  localparam logic [1:0] MOD3 [ALPHA_SIZE] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0
  };

  typedef struct packed {
    logic                 direction;
    logic [KEY_LEN_W-1:0] key_length;
    logic [63:0]          key_bytes_low;
    logic [63:0]          key_bytes_high;
  } kbc_cfg_t;

  typedef struct packed {
    logic [KEY_POS_W-1:0] key_position;
    logic [1:0]           alphabet_choice;
  } kbc_state_t;

  typedef struct packed {
    byte_t plain_byte;
    byte_t text_char_first;
    byte_t text_char_second;
    logic  last_item;
  } kbc_item_t;

  typedef struct packed {
    byte_t code_char_first;
    byte_t code_char_second;
    byte_t restored_byte;
    logic  bad_char;
    logic  end_of_message;
  } kbc_result_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       bad;
  } nib_lookup_t;

  // reverse search through the union of alphabets: first table hit wins
  function automatic nib_lookup_t char_to_nibble(input byte_t ch);
    nib_lookup_t res;
    res.nibble = 4'd0;
    res.bad    = 1'b1;
    for (int a = ALPHA_COUNT - 1; a >= 0; a--) begin
      for (int n = ALPHA_SIZE - 1; n >= 0; n--) begin
        if (ALPHA[a][n] == ch) begin
          res.nibble = 4'(n);
          res.bad    = 1'b0;
        end
      end
    end
    return res;
  endfunction

endpackage

>>> hdl/kbc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbc_core
// per-item transform: key byte select, cipher add or subtract, nibble
// alphabet encode or decode, and next key position and alphabet choice
// ----------------------------------------------------------------------------
module kbc_core (
  input  kbc_pkg::kbc_cfg_t    cfg,
  input  kbc_pkg::kbc_state_t  state,
  input  kbc_pkg::kbc_item_t   item,
  output kbc_pkg::kbc_result_t result,
  output kbc_pkg::kbc_state_t  state_next
);
  import kbc_pkg::*;

  logic [127:0]         key_all;
  byte_t                key;
  logic [KEY_LEN_W-1:0] len_eff;
  logic [KEY_LEN_W-1:0] pos_inc;
  logic [1:0]           alph;
  byte_t                ciph;
  logic [3:0]           enc_lo;
  logic [3:0]           enc_hi;
  nib_lookup_t          dec_lo;
  nib_lookup_t          dec_hi;
  logic [3:0]           hi_used;

  assign key_all = {cfg.key_bytes_high, cfg.key_bytes_low};
  assign key     = key_all[{state.key_position, 3'b000} +: 8];

  // key length clamped to 1..max
  always_comb begin
    if (cfg.key_length == '0) begin
      len_eff = KEY_LEN_W'(1);
    end else if (cfg.key_length > KEY_LEN_W'(KEY_BYTES_MAX)) begin
      len_eff = KEY_LEN_W'(KEY_BYTES_MAX);
    end else begin
      len_eff = cfg.key_length;
    end
  end

  assign alph   = (state.alphabet_choice == 2'd3) ? 2'd0 : state.alphabet_choice;
  assign ciph   = item.plain_byte - key;
  assign enc_lo = ciph[3:0];
  assign enc_hi = ciph[7:4];
  assign dec_lo = char_to_nibble(item.text_char_first);
  assign dec_hi = char_to_nibble(item.text_char_second);

  always_comb begin
    result = '0;
    result.end_of_message = item.last_item;
    if (cfg.direction == DIR_ENCODE) begin
      result.code_char_first  = ALPHA[alph][enc_lo];
      result.code_char_second = ALPHA[MOD3[enc_lo]][enc_hi];
      hi_used                 = enc_hi;
    end else begin
      result.restored_byte = {dec_hi.nibble, dec_lo.nibble} + key;
      result.bad_char      = dec_lo.bad | dec_hi.bad;
      hi_used              = dec_hi.nibble;
    end
  end

  assign pos_inc = {1'b0, state.key_position} + KEY_LEN_W'(1);

  always_comb begin
    if (item.last_item) begin
      state_next = '0;
    end else begin
      state_next.alphabet_choice = MOD3[hi_used];
      state_next.key_position    = (pos_inc >= len_eff) ? '0 : pos_inc[KEY_POS_W-1:0];
    end
  end

endmodule

>>> hdl/keyed_byte_cipher_nibble_codec_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_byte_cipher_nibble_codec_top
// keyed byte cipher with a three-alphabet nibble text codec, encode or
// decode per the direction register, one result beat per input beat
// ----------------------------------------------------------------------------
// path: input beat to result beat through the input register, then the
// result register; throughput: one beat per cycle while out_stall is low,
// set by the single registered pass through kbc_core with the key/alphabet
// state updated as the item leaves the input register
// reset (rst, synchronous): pipeline empty, key position and alphabet 0,
// direction encode, key length 1, key bytes 0
module keyed_byte_cipher_nibble_codec_top (
  input  logic                         clk,
  input  logic                         rst,
  // input beat channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   plain_byte,
  input  logic [7:0]                   text_char_first,
  input  logic [7:0]                   text_char_second,
  input  logic                         last_item,
  // result beat channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   code_char_first,
  output logic [7:0]                   code_char_second,
  output logic [7:0]                   restored_byte,
  output logic                         bad_char,
  output logic                         end_of_message,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kbc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [kbc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [kbc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                         pready
);
  import kbc_pkg::*;

  // configuration registers
  kbc_cfg_t    cfg;
  reg_index_t  reg_sel;
  logic        cfg_write;

  // input register stage
  logic        s1_valid;
  kbc_item_t   s1_item;
  logic        s1_advance;
  logic        out_free;
  logic        in_accept;

  // running state and result register
  kbc_state_t  state;
  kbc_state_t  state_next;
  kbc_result_t core_result;
  kbc_result_t out_result;

  // ---------------------------------------------------------------------------
  // register file: 8-byte spacing since the key registers are 64 bits
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[4:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction      <= DIR_ENCODE;
      cfg.key_length     <= KEY_LEN_W'(1);
      cfg.key_bytes_low  <= '0;
      cfg.key_bytes_high <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_DIRECTION:  cfg.direction      <= pwdata[0];
        REG_KEY_LENGTH: cfg.key_length     <= pwdata[KEY_LEN_W-1:0];
        REG_KEY_LOW:    cfg.key_bytes_low  <= pwdata;
        REG_KEY_HIGH:   cfg.key_bytes_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DIRECTION:  prdata = CFG_DATA_W'(cfg.direction);
      REG_KEY_LENGTH: prdata = CFG_DATA_W'(cfg.key_length);
      REG_KEY_LOW:    prdata = cfg.key_bytes_low;
      REG_KEY_HIGH:   prdata = cfg.key_bytes_high;
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: the result register frees up when empty or being taken;
  // the input register then drains into it, and accepts a new beat the
  // same cycle
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && out_free;
  assign in_stall   = s1_valid && !out_free;
  assign in_accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.plain_byte       <= plain_byte;
      s1_item.text_char_first  <= text_char_first;
      s1_item.text_char_second <= text_char_second;
      s1_item.last_item        <= last_item;
    end
  end

  // ---------------------------------------------------------------------------
  // cipher and nibble codec
  // ---------------------------------------------------------------------------
  kbc_core u_core (
    .cfg        (cfg),
    .state      (state),
    .item       (s1_item),
    .result     (core_result),
    .state_next (state_next)
  );

  // key position and alphabet move on only when an item leaves the input
  // register, so back-to-back items see the state of their predecessor
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_result <= core_result;
    end
  end

  assign code_char_first  = out_result.code_char_first;
  assign code_char_second = out_result.code_char_second;
  assign restored_byte    = out_result.restored_byte;
  assign bad_char         = out_result.bad_char;
  assign end_of_message   = out_result.end_of_message;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // alphabet choice only ever holds a nibble mod 3
  a_alpha_range : assert property (@(posedge clk) disable iff (rst)
    state.alphabet_choice != 2'd3)
    else $error("alphabet choice out of range");

  // stall is only raised with a beat waiting in the input register
  a_stall_has_beat : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // a last beat leaving the input register restarts the message state
  a_last_clears : assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_item.last_item) |=> (state == '0))
    else $error("state not cleared after end of message");

  // a beat handed to the result register shows up as a valid result
  a_advance_valid : assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("result lost after advance");

endmodule

>>> dv/kbc_codec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbc_codec_checker
// watches the configuration port and both beat channels of the keyed byte
// cipher nibble codec, keeps its own cipher and alphabet state, and compares
// every result beat field by field with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module kbc_codec_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     plain_byte,
  input  logic [7:0]                     text_char_first,
  input  logic [7:0]                     text_char_second,
  input  logic                           last_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [7:0]                     code_char_first,
  input  logic [7:0]                     code_char_second,
  input  logic [7:0]                     restored_byte,
  input  logic                           bad_char,
  input  logic                           end_of_message,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [kbc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [kbc_pkg::CFG_DATA_W-1:0] pwdata,
  output int unsigned                    mismatches,
  output int unsigned                    outstanding
);
  import kbc_pkg::*;

  // nibble 0 is the first character of each string
  localparam logic [127:0] GLYPHS [3] = '{
    "a0sgA6uCd8wj5oGl",
    "qI3bKFyxht1eJLpm",
    "D9k4z7fBrviEcH2n"
  };

  logic        mode_dir;
  logic [4:0]  key_len;
  logic [63:0] key_lo;
  logic [63:0] key_hi;
  int unsigned key_pos;
  logic [1:0]  alpha_sel;
  int unsigned beat_no;

  kbc_result_t codes_due [$];

  initial mismatches = 0;
  initial outstanding = 0;

  function automatic byte_t glyph(logic [1:0] set, logic [3:0] nib);
    return GLYPHS[set][8*(15-nib) +: 8];
  endfunction

  // {unknown, nibble}; first hit in table order
  function automatic logic [4:0] glyph_value(byte_t ch);
    for (int s = 0; s < 3; s++)
      for (int n = 0; n < 16; n++)
        if (glyph(2'(s), 4'(n)) == ch) return {1'b0, 4'(n)};
    return 5'b1_0000;
  endfunction

  function automatic kbc_result_t codec_step(byte_t pb, byte_t c_lo, byte_t c_hi,
                                             logic fin);
    kbc_result_t r;
    int unsigned span;
    byte_t key, ciph;
    logic [3:0] lo, hi;
    logic [4:0] v_lo, v_hi;
    logic [1:0] sel;
    span = (key_len == 0) ? 1 : ((key_len > KEY_BYTES_MAX) ? KEY_BYTES_MAX : key_len);
    key = (key_pos < 8) ? key_lo[8*key_pos +: 8] : key_hi[8*(key_pos-8) +: 8];
    sel = (alpha_sel > 2) ? 2'd0 : alpha_sel;
    r = '0;
    if (mode_dir == DIR_ENCODE) begin
      ciph = pb - key;
      lo = ciph[3:0];
      hi = ciph[7:4];
      r.code_char_first  = glyph(sel, lo);
      r.code_char_second = glyph(2'(int'(lo) % 3), hi);
    end else begin
      v_lo = glyph_value(c_lo);
      v_hi = glyph_value(c_hi);
      lo = v_lo[3:0];
      hi = v_hi[3:0];
      r.restored_byte = {hi, lo} + key;
      r.bad_char = v_lo[4] | v_hi[4];
    end
    r.end_of_message = fin;
    // next alphabet follows the raw high nibble in both directions
    alpha_sel = 2'(int'(hi) % 3);
    key_pos = key_pos + 1;
    if (key_pos >= span) key_pos = 0;
    if (fin) begin
      key_pos = 0;
      alpha_sel = 2'd0;
    end
    return r;
  endfunction

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic cmp_field(string field, logic [7:0] got, logic [7:0] want);
    if (got != want)
      report($sformatf("beat %0d %s got %0h want %0h", beat_no, field, got, want));
  endtask

  always @(posedge clk) begin : watch
    kbc_result_t want;
    if (rst) begin
      mode_dir  = DIR_ENCODE;
      key_len   = 5'd1;
      key_lo    = '0;
      key_hi    = '0;
      key_pos   = 0;
      alpha_sel = 2'd0;
      beat_no   = 0;
      codes_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[4:3]))
          REG_DIRECTION:  mode_dir = pwdata[0];
          REG_KEY_LENGTH: key_len  = pwdata[4:0];
          REG_KEY_LOW:    key_lo   = pwdata;
          REG_KEY_HIGH:   key_hi   = pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        codes_due.push_back(codec_step(plain_byte, text_char_first, text_char_second,
                                       last_item));
      if (out_valid && !out_stall) begin
        if (codes_due.size() == 0) begin
          report($sformatf("beat %0d arrived with nothing expected", beat_no));
        end else begin
          want = codes_due.pop_front();
          cmp_field("code_char_first", code_char_first, want.code_char_first);
          cmp_field("code_char_second", code_char_second, want.code_char_second);
          cmp_field("restored_byte", restored_byte, want.restored_byte);
          cmp_field("bad_char", 8'(bad_char), 8'(want.bad_char));
          cmp_field("end_of_message", 8'(end_of_message), 8'(want.end_of_message));
        end
        beat_no++;
      end
    end
    outstanding <= codes_due.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the keyed byte cipher nibble codec: a directed
// opening over byte and key extremes, known and unknown characters and a
// mode switch inside a message, then randomized phases with varied key
// settings, framed messages and random idling on both channels
// ----------------------------------------------------------------------------
module tb;
  import kbc_pkg::*;

  // cycles with no beat or register access before giving up
  localparam int unsigned STUCK_LIMIT = 1000;
  // all 48 characters of the three alphabets
  localparam logic [8*48-1:0] GLYPH_POOL =
    "a0sgA6uCd8wj5oGlqI3bKFyxht1eJLpmD9k4z7fBrviEcH2n";

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] plain_byte = '0;
  logic [7:0] text_char_first = '0;
  logic [7:0] text_char_second = '0;
  logic       last_item = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] code_char_first;
  logic [7:0] code_char_second;
  logic [7:0] restored_byte;
  logic       bad_char;
  logic       end_of_message;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatches;
  int unsigned outstanding;

  // shared between the sender and the receiver processes
  int unsigned beats_in = 0;
  bit          calm = 1'b0;      // no idling on either side
  bit          squeeze = 1'b0;   // long receiver hold in progress
  bit          squeeze_done = 1'b0;

  always #10 clk = ~clk;

  keyed_byte_cipher_nibble_codec_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .plain_byte       (plain_byte),
    .text_char_first  (text_char_first),
    .text_char_second (text_char_second),
    .last_item        (last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .code_char_first  (code_char_first),
    .code_char_second (code_char_second),
    .restored_byte    (restored_byte),
    .bad_char         (bad_char),
    .end_of_message   (end_of_message),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  kbc_codec_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .plain_byte       (plain_byte),
    .text_char_first  (text_char_first),
    .text_char_second (text_char_second),
    .last_item        (last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .code_char_first  (code_char_first),
    .code_char_second (code_char_second),
    .restored_byte    (restored_byte),
    .bad_char         (bad_char),
    .end_of_message   (end_of_message),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly alphabet characters, sometimes any byte at all
  function automatic byte_t pick_text();
    int unsigned k;
    if ($urandom_range(0, 9) == 0) return byte_t'($urandom_range(0, 255));
    k = $urandom_range(0, 47);
    return GLYPH_POOL[8*k +: 8];
  endfunction

  // setup phase, access phase, then an idle phase so psel drops cleanly
  task automatic cfg_write(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // offer one input beat and hold it until the block takes it;
  // valid is only dropped when an idle gap is wanted
  task automatic send_beat(input byte_t pb, input byte_t c_lo, input byte_t c_hi,
                           input logic fin);
    int unsigned gap;
    gap = (calm || squeeze) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    plain_byte       <= pb;
    text_char_first  <= c_lo;
    text_char_second <= c_hi;
    last_item        <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_in++;
  endtask

  // stop offering, let every predicted beat come out, then let the
  // two-stage pipeline go quiet before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // result side: random stall runs, one long hold once traffic is flowing
  initial begin : receiver
    int unsigned n;
    forever begin
      if (!squeeze_done && beats_in >= 100) begin
        squeeze = 1'b1;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        squeeze = 1'b0;
        squeeze_done = 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        n = idle_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // no progress on any channel for too long means the block hung
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        stuck = 0;
      else
        stuck++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned msg_left;
    logic fin;
    msg_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // encode with key bytes 00, 01, ff repeating over three: byte extremes,
    // nibble extremes and a borrow through zero
    cfg_write(REG_DIRECTION, 64'(DIR_ENCODE));
    cfg_write(REG_KEY_LENGTH, 64'd3);
    cfg_write(REG_KEY_LOW, 64'h0000_0000_00ff_0100);
    cfg_write(REG_KEY_HIGH, 64'hff00_0000_0000_0080);
    send_beat(8'h00, 8'h00, 8'hff, 1'b0);
    send_beat(8'hff, 8'hff, 8'h00, 1'b0);
    send_beat(8'h0f, "a", "n", 1'b0);
    send_beat(8'hf0, "a", "n", 1'b0);
    send_beat(8'h5a, "q", "m", 1'b1);
    send_beat(8'h01, "D", "l", 1'b0);
    send_beat(8'h80, 8'h00, 8'h00, 1'b0);
    settle();

    // switch to decode in the middle of the message: key position and
    // alphabet carry on; first and last glyphs, unknown characters on
    // either side and on both
    cfg_write(REG_DIRECTION, 64'(DIR_DECODE));
    send_beat(8'hff, "a", "a", 1'b0);
    send_beat(8'h00, "n", "n", 1'b0);
    send_beat(8'h55, "q", "2", 1'b0);
    send_beat(8'haa, 8'h00, "a", 1'b0);
    send_beat(8'h00, "a", 8'hff, 1'b0);
    send_beat(8'hff, 8'h80, 8'h7f, 1'b0);
    send_beat(8'h12, "D", "l", 1'b1);
    send_beat(8'h34, "9", "m", 1'b0);
    settle();

    // random phases; messages run across phase boundaries, so mode and key
    // changes also land inside messages
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_DIRECTION, 64'(ph[0] ? DIR_DECODE : DIR_ENCODE));
      case (ph)
        0: cfg_write(REG_KEY_LENGTH, 64'd0);    // zero length acts as one
        1: cfg_write(REG_KEY_LENGTH, 64'd16);
        2: cfg_write(REG_KEY_LENGTH, 64'd31);   // beyond the key store
        3: cfg_write(REG_KEY_LENGTH, 64'd1);
        4: cfg_write(REG_KEY_LENGTH, 64'd17);
        default: cfg_write(REG_KEY_LENGTH, 64'($urandom_range(1, 16)));
      endcase
      case (ph % 3)
        0: begin
          cfg_write(REG_KEY_LOW, '1);
          cfg_write(REG_KEY_HIGH, '1);
        end
        1: begin
          cfg_write(REG_KEY_LOW, '0);
          cfg_write(REG_KEY_HIGH, '0);
        end
        default: begin
          cfg_write(REG_KEY_LOW, {$urandom, $urandom});
          cfg_write(REG_KEY_HIGH, {$urandom, $urandom});
        end
      endcase
      calm = (ph == 5);
      for (int i = 0; i < 48; i++) begin
        // framed messages, long enough to wrap the key several times
        if (msg_left == 0)
          msg_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                 : $urandom_range(5, 40);
        fin = (msg_left == 1);
        msg_left--;
        // occasional broken framing: an early or missing end marker
        if ($urandom_range(0, 15) == 0) begin
          fin = 1'($urandom_range(0, 1));
          if (fin) msg_left = 0;
        end
        send_beat(byte_t'($urandom_range(0, 255)), pick_text(), pick_text(), fin);
      end
      settle();
      calm = 1'b0;
    end

    repeat (6) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
